// File: design/pal_pkg.sv
// pal_pkg: shared constants, codes and types for the positional array list.
// Used by pal_cell, pal_ctrl and positional_array_list_core. No dependencies.
package pal_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_IN_W = 5;
    localparam int CMP_W    = (CNT_W > POS_IN_W) ? CNT_W : POS_IN_W;

    typedef logic [31:0]      word_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [CMP_W-1:0] cmp_t;

    localparam logic [2:0] ACT_INSERT_AT    = 3'd0;
    localparam logic [2:0] ACT_INSERT_FIRST = 3'd1;
    localparam logic [2:0] ACT_INSERT_LAST  = 3'd2;
    localparam logic [2:0] ACT_DELETE_AT    = 3'd3;
    localparam logic [2:0] ACT_REPLACE_AT   = 3'd4;
    localparam logic [2:0] ACT_SEARCH       = 3'd5;
    localparam logic [2:0] ACT_READ_AT      = 3'd6;
    localparam logic [2:0] ACT_CLEAR        = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // per-cell update command
    typedef struct packed {
        logic load;
        logic from_left;
        logic from_right;
    } cell_cmd_t;

    // list operation broadcast to the cell row
    typedef struct packed {
        logic ins;
        logic del;
        logic rep;
        cmp_t pos;
    } list_op_t;

    // one result item
    typedef struct packed {
        logic [2:0] status;
        word_t      value;
        idx_t       found;
        cnt_t       count;
    } resp_t;

endpackage

// File: design/pal_cell.sv
// pal_cell: one storage cell of the list row; holds a word, shifts to/from
// its neighbors, and compares against the search key. Depends on pal_pkg.
module pal_cell (
    input  logic                aclk,
    input  pal_pkg::cell_cmd_t  cmd,
    input  pal_pkg::word_t      item,
    input  pal_pkg::word_t      left_data,
    input  pal_pkg::word_t      right_data,
    output pal_pkg::word_t      data,
    output logic                match
);

    pal_pkg::word_t data_reg;
    pal_pkg::word_t data_next;

    always_comb begin
        priority if (cmd.load) begin
            data_next = item;
        end else if (cmd.from_left) begin
            data_next = left_data;
        end else if (cmd.from_right) begin
            data_next = right_data;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == item);

endmodule

// File: design/pal_ctrl.sv
// pal_ctrl: request decode for the list; checks bounds against the length,
// picks the row operation and forms the result. Depends on pal_pkg.
module pal_ctrl (
    input  logic              accept,
    input  logic [2:0]        action,
    input  logic [4:0]        position,
    input  pal_pkg::cnt_t     count,
    input  logic              hit,
    input  pal_pkg::idx_t     hit_idx,
    input  pal_pkg::word_t    rd_data,
    output pal_pkg::list_op_t op,
    output pal_pkg::resp_t    resp
);

    pal_pkg::cmp_t pos_ext;
    pal_pkg::cmp_t cnt_ext;
    pal_pkg::cmp_t ins_pos;
    logic          full;

    assign pos_ext = pal_pkg::cmp_t'(position);
    assign cnt_ext = pal_pkg::cmp_t'(count);
    assign full    = (cnt_ext >= pal_pkg::cmp_t'(pal_pkg::CAPACITY));

    always_comb begin
        op          = '0;
        resp.status = pal_pkg::ST_OK;
        resp.value  = '0;
        resp.found  = '0;
        resp.count  = count;
        ins_pos     = pos_ext;

        unique case (action)
            pal_pkg::ACT_INSERT_AT, pal_pkg::ACT_INSERT_FIRST,
            pal_pkg::ACT_INSERT_LAST: begin
                if (action == pal_pkg::ACT_INSERT_FIRST) begin
                    ins_pos = '0;
                end else if (action == pal_pkg::ACT_INSERT_LAST) begin
                    ins_pos = cnt_ext;
                end
                if (full) begin
                    resp.status = pal_pkg::ST_FULL;
                end else if (ins_pos > cnt_ext) begin
                    resp.status = pal_pkg::ST_BADPOS;
                end else begin
                    op.ins     = accept;
                    op.pos     = ins_pos;
                    resp.count = count + pal_pkg::cnt_t'(1);
                end
            end
            pal_pkg::ACT_DELETE_AT, pal_pkg::ACT_REPLACE_AT,
            pal_pkg::ACT_READ_AT: begin
                if (count == '0) begin
                    resp.status = pal_pkg::ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    resp.status = pal_pkg::ST_BADPOS;
                end else begin
                    resp.value = rd_data;
                    op.pos     = pos_ext;
                    if (action == pal_pkg::ACT_DELETE_AT) begin
                        op.del     = accept;
                        resp.count = count - pal_pkg::cnt_t'(1);
                    end else if (action == pal_pkg::ACT_REPLACE_AT) begin
                        op.rep = accept;
                    end
                end
            end
            pal_pkg::ACT_SEARCH: begin
                if (hit) begin
                    resp.found = hit_idx;
                end else begin
                    resp.status = pal_pkg::ST_NOTFOUND;
                end
            end
            pal_pkg::ACT_CLEAR: begin
                resp.count = '0;
            end
            default: begin
                resp.count = count;
            end
        endcase
    end

endmodule

// File: design/positional_array_list_core.sv
// positional_array_list_core: top level of the ordered word list.
// Depends on pal_pkg, pal_cell and pal_ctrl.
//
// Ordered list of up to CAPACITY unsigned 32-bit words held in a row of cells,
// one word per cell; inserts and deletes move every cell above the position
// one step along the row, and a search compares all cells at once and takes
// the lowest matching index below the length. Every request yields exactly
// one result, held in an output register; a new request is taken whenever
// that register is empty or is being transferred in the same cycle, so one
// request per cycle is sustained while the result side keeps up. Reset clears
// the length and the output valid flag only; cell contents are never read
// before they are written.
module positional_array_list_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [4:0]  s_position,
    input  logic [31:0] s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_value_out,
    output logic [3:0]  m_found_index,
    output logic [4:0]  m_count_now
);

    localparam int N = pal_pkg::CAPACITY;

    pal_pkg::word_t    cell_data  [N];
    logic [N-1:0]      cell_match;
    pal_pkg::list_op_t op;
    pal_pkg::resp_t    resp;
    pal_pkg::cnt_t     count_reg;
    pal_pkg::cnt_t     count_next;
    pal_pkg::resp_t    resp_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              fire;
    logic              hit;
    pal_pkg::idx_t     hit_idx;
    pal_pkg::word_t    rd_data;
    pal_pkg::cmp_t     rd_pos;

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            pal_pkg::cell_cmd_t cmd;
            pal_pkg::word_t     left_data;
            pal_pkg::word_t     right_data;

            assign cmd.load       = (op.ins || op.rep) && (op.pos == pal_pkg::cmp_t'(gi));
            assign cmd.from_left  = op.ins && (op.pos < pal_pkg::cmp_t'(gi));
            assign cmd.from_right = op.del && (op.pos <= pal_pkg::cmp_t'(gi));

            if (gi == 0) begin : g_first
                assign left_data = s_item;
            end else begin : g_mid
                assign left_data = cell_data[gi-1];
            end
            if (gi == N - 1) begin : g_last
                assign right_data = cell_data[gi];
            end else begin : g_inner
                assign right_data = cell_data[gi+1];
            end

            pal_cell u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .item       (s_item),
                .left_data  (left_data),
                .right_data (right_data),
                .data       (cell_data[gi]),
                .match      (cell_match[gi])
            );
        end
    endgenerate

    // lowest matching cell inside the live part of the list
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (cell_match[i] && (pal_pkg::cnt_t'(i) < count_reg)) begin
                hit     = 1'b1;
                hit_idx = pal_pkg::idx_t'(i);
            end
        end
    end

    assign rd_pos = pal_pkg::cmp_t'(s_position);

    always_comb begin
        if (rd_pos < pal_pkg::cmp_t'(N)) begin
            rd_data = cell_data[rd_pos[pal_pkg::IDX_W-1:0]];
        end else begin
            rd_data = '0;
        end
    end

    pal_ctrl u_ctrl (
        .accept   (fire),
        .action   (s_action),
        .position (s_position),
        .count    (count_reg),
        .hit      (hit),
        .hit_idx  (hit_idx),
        .rd_data  (rd_data),
        .op       (op),
        .resp     (resp)
    );

    assign count_next   = fire ? resp.count : count_reg;
    assign m_valid_next = fire || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            resp_reg <= resp;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = resp_reg.status;
    assign m_value_out   = resp_reg.value;
    assign m_found_index = 4'(resp_reg.found);
    assign m_count_now   = 5'(resp_reg.count);

endmodule
